// ----- rtl/gtq_pkg.sv -----
// gtq_pkg: shared sizes, codes and word types for the grouped team queue.
// No dependencies; imported by gtq_free_list and grouped_team_queue.
package gtq_pkg;

    localparam int ID_BITS   = 10;
    localparam int TEAM_BITS = 4;
    localparam int POOL_BITS = 8;
    localparam int MAX_TEAMS = 1 << TEAM_BITS;
    localparam int POOL_SIZE = 1 << POOL_BITS;
    localparam int ID_DEPTH  = 1 << ID_BITS;

    typedef enum logic [1:0] {
        CMD_ASSIGN = 2'd0,
        CMD_PUSH   = 2'd1,
        CMD_POP    = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]           command;
        logic [ID_BITS-1:0]   element_id;
        logic [TEAM_BITS-1:0] team;
    } req_word_t;

    typedef struct packed {
        logic [ID_BITS-1:0] popped_id;
        logic [1:0]         status;
    } rsp_word_t;

    // free list control from the sequencer
    typedef struct packed {
        logic                 rd;
        logic                 alloc;
        logic                 rel;
        logic                 clr;
        logic [POOL_BITS-1:0] rel_slot;
    } free_ctl_t;

    typedef struct packed {
        logic [POOL_BITS-1:0] slot;
        logic                 empty;
        logic                 full;
    } free_sts_t;

endpackage

// ----- rtl/gtq_free_list.sv -----
// gtq_free_list: ring of free pool slots with head, count and fill count.
// Depends on gtq_pkg.
module gtq_free_list
    import gtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  free_ctl_t ctl,
    output free_sts_t sts
);

    logic [POOL_BITS-1:0] ring_mem [POOL_SIZE];
    logic [POOL_BITS-1:0] head_reg, head_next;
    logic [POOL_BITS:0]   count_reg, count_next;
    logic [POOL_BITS:0]   fill_reg, fill_next;   // ring positions written since clear
    logic [POOL_BITS-1:0] rd_data_reg;
    logic                 fresh_reg;
    logic [POOL_BITS-1:0] tail_pos;

    assign tail_pos = head_reg + count_reg[POOL_BITS-1:0];

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        if (ctl.clr)
        begin
            head_next  = '0;
            count_next = (POOL_BITS+1)'(POOL_SIZE);
            fill_next  = '0;
        end
        else if (ctl.alloc)
        begin
            head_next  = head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (ctl.rel)
        begin
            count_next = count_reg + 1'b1;
            if (fill_reg != (POOL_BITS+1)'(POOL_SIZE))
                fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= (POOL_BITS+1)'(POOL_SIZE);
            fill_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rel && !ctl.clr)
            ring_mem[tail_pos] <= ctl.rel_slot;
        if (ctl.rd)
        begin
            rd_data_reg <= ring_mem[head_reg];
            fresh_reg   <= ({1'b0, head_reg} >= fill_reg);
        end
    end

    // unwritten positions read as their own index
    assign sts.slot  = fresh_reg ? head_reg : rd_data_reg;
    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg == (POOL_BITS+1)'(POOL_SIZE));

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (POOL_BITS+1)'(POOL_SIZE))
        else $error("free count above pool size");
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (POOL_BITS+1)'(POOL_SIZE))
        else $error("fill count above pool size");
    a_no_alloc_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.alloc |-> count_reg != '0)
        else $error("alloc from empty free list");

endmodule

// ----- rtl/grouped_team_queue.sv -----
// grouped_team_queue: queue of team FIFOs over a shared linked slot pool.
// Depends on gtq_pkg and gtq_free_list.
// Each accepted word is registered (accept step), then run in S_EXEC, which
// registers the result word; no new word is taken until it is done. Execute
// does the dependent pool and team memory writes; memories are read on accept.
// A result held by rsp_stall holds the sequencer in execute.
// Reset: async active low; queues empty, free ring in slot order, the
// id-to-team table and pool contents are undefined until written.
module grouped_team_queue
    import gtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t state_reg;
    logic   accept, done;

    // accepted word
    logic [1:0]           cmd_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [TEAM_BITS-1:0] team_reg;

    // memories with registered read data
    logic [TEAM_BITS-1:0] team_of_id [ID_DEPTH];
    logic [ID_BITS-1:0]   slot_value [POOL_SIZE];
    logic [POOL_BITS-1:0] slot_next  [POOL_SIZE];
    logic [TEAM_BITS-1:0] tod_rd_reg;
    logic [ID_BITS-1:0]   val_rd_reg;
    logic [POOL_BITS-1:0] nxt_rd_reg;

    // per-team flops and team order ring
    logic [POOL_BITS-1:0] team_head [MAX_TEAMS];
    logic [POOL_BITS-1:0] team_tail [MAX_TEAMS];
    logic [MAX_TEAMS-1:0] waiting_reg;
    logic [TEAM_BITS-1:0] order_ring [MAX_TEAMS];
    logic [TEAM_BITS-1:0] order_head_reg;
    logic [TEAM_BITS:0]   order_count_reg;

    free_ctl_t fctl;
    free_sts_t fsts;

    // front team and its head slot (stable while a word executes)
    logic [TEAM_BITS-1:0] front_team;
    logic [POOL_BITS-1:0] front_slot;
    logic [TEAM_BITS-1:0] order_tail;
    logic                 do_push, do_pop, do_assign, do_clear;
    logic                 push_joins;

    // result word built from the executing command
    rsp_word_t rsp_next;

    assign accept     = req_valid && !req_stall;
    assign req_stall  = (state_reg != S_IDLE);
    assign done       = (state_reg == S_EXEC) && !(rsp_valid && rsp_stall);

    assign front_team = order_ring[order_head_reg];
    assign front_slot = team_head[front_team];
    assign order_tail = order_head_reg + order_count_reg[TEAM_BITS-1:0];

    assign do_assign  = done && (cmd_reg == CMD_ASSIGN);
    assign do_push    = done && (cmd_reg == CMD_PUSH) && !fsts.empty;
    assign do_pop     = done && (cmd_reg == CMD_POP) && (order_count_reg != '0);
    assign do_clear   = done && (cmd_reg == CMD_CLEAR);
    assign push_joins = waiting_reg[tod_rd_reg];

    assign fctl.rd       = accept;
    assign fctl.alloc    = do_push;
    assign fctl.rel      = do_pop && !fsts.full;
    assign fctl.clr      = do_clear;
    assign fctl.rel_slot = front_slot;

    gtq_free_list u_free (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fctl),
        .sts   (fsts)
    );

    // memory ports: reads on accept, writes on execute
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tod_rd_reg <= team_of_id[req.element_id];
            val_rd_reg <= slot_value[front_slot];
            nxt_rd_reg <= slot_next[front_slot];
        end
        if (do_assign)
            team_of_id[id_reg] <= team_reg;
        if (do_push)
        begin
            slot_value[fsts.slot] <= id_reg;
            if (push_joins)
                slot_next[team_tail[tod_rd_reg]] <= fsts.slot;
        end
    end

    // team pointers and order ring (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.command;
            id_reg   <= req.element_id;
            team_reg <= req.team;
        end
        if (do_push)
        begin
            team_tail[tod_rd_reg] <= fsts.slot;
            if (!push_joins)
            begin
                team_head[tod_rd_reg]  <= fsts.slot;
                order_ring[order_tail] <= tod_rd_reg;
            end
        end
        else if (do_pop && (front_slot != team_tail[front_team]))
            team_head[front_team] <= nxt_rd_reg;
    end

    // status and popped id for the executing word
    always_comb
    begin
        rsp_next = '{popped_id: '0, status: ST_DONE};
        case (cmd_reg)
            CMD_PUSH:
            begin
                if (fsts.empty)
                    rsp_next.status = ST_FULL;
            end
            CMD_POP:
            begin
                if (order_count_reg == '0)
                    rsp_next.status = ST_EMPTY;
                else
                begin
                    rsp_next.status    = ST_POPPED;
                    rsp_next.popped_id = val_rd_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer, control state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rsp_valid       <= 1'b0;
            rsp             <= '0;
            waiting_reg     <= '0;
            order_head_reg  <= '0;
            order_count_reg <= '0;
        end
        else
        begin
            if (done)
            begin
                rsp_valid <= 1'b1;
                rsp       <= rsp_next;
            end
            else if (rsp_valid && !rsp_stall)
                rsp_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (done)
                    begin
                        state_reg <= S_IDLE;
                        case (cmd_reg)
                            CMD_PUSH:
                            begin
                                if (!fsts.empty && !push_joins)
                                begin
                                    waiting_reg[tod_rd_reg] <= 1'b1;
                                    if (order_count_reg != (TEAM_BITS+1)'(MAX_TEAMS))
                                        order_count_reg <= order_count_reg + 1'b1;
                                end
                            end
                            CMD_POP:
                            begin
                                // team leaves the order once its FIFO drains
                                if ((order_count_reg != '0) &&
                                    (front_slot == team_tail[front_team]))
                                begin
                                    waiting_reg[front_team] <= 1'b0;
                                    order_head_reg  <= order_head_reg + 1'b1;
                                    order_count_reg <= order_count_reg - 1'b1;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                waiting_reg     <= '0;
                                order_head_reg  <= '0;
                                order_count_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_waiting_matches_order: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(waiting_reg) == 32'(order_count_reg))
        else $error("waiting teams differ from order count");
    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        order_count_reg <= (TEAM_BITS+1)'(MAX_TEAMS))
        else $error("order count above team count");
    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ST_POPPED) |-> rsp.popped_id == '0)
        else $error("popped id set without a pop");
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted word did not execute");

endmodule
